@@ sv/qewc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the quadrature encoder wheel counter: request and result payload
// types, the sample record passed to the speed pipeline, and fixed constants.
// Depends on nothing; every other file of the block imports it.
package qewc_pkg;

    localparam logic OP_EDGE   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register index carried on paddr[2]; the scale register is the only one.
    localparam logic REG_SPEED_SCALE = 1'b0;

    localparam logic [31:0] SPEED_SCALE_RESET = 32'd65536;

    localparam logic [47:0] SPEED_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SPEED_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic       opcode;
        logic [1:0] wheel_index;
        logic       a_level;
        logic       b_level;
    } qewc_in_t;

    typedef struct packed {
        logic signed [31:0] delta_count;
        logic signed [31:0] total_count;
        logic signed [47:0] speed_q8;
        logic [1:0]         sample_wheel;
    } qewc_out_t;

    // Sample record from the counter memory stage to the speed pipeline.
    typedef struct packed {
        logic [31:0] delta;
        logic [31:0] total;
        logic [31:0] mag;
        logic        neg;
        logic [1:0]  wheel;
    } qewc_smp_t;

endpackage

@@ sv/qewc_cfg.sv @@
`timescale 1ns / 1ps
// APB-style configuration port holding the speed scale register.
// Depends on qewc_pkg for the register index and reset value.
module qewc_cfg
    import qewc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] speed_scale
);

    logic [31:0] scale_reg;
    logic [31:0] scale_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SPEED_SCALE);

    always_comb
    begin
        scale_next = wr_en ? pwdata : scale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SPEED_SCALE_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
        end
    end

    assign prdata      = (paddr[2] == REG_SPEED_SCALE) ? scale_reg : 32'd0;
    assign speed_scale = scale_reg;

endmodule

@@ sv/qewc_ctr.sv @@
`timescale 1ns / 1ps
// Counter memory stage: one synchronous RAM of {total, interval} per wheel with
// read-modify-write, per-entry valid bits and same-edge forwarding.
// Depends on qewc_pkg for the request and sample record types.
module qewc_ctr
    import qewc_pkg::*;
#(
    parameter int WHEELS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      evt_valid,
    output logic      evt_stall,
    input  qewc_in_t  evt,
    output logic      smp_valid,
    input  logic      smp_stall,
    output qewc_smp_t smp
);

    localparam int AW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic [63:0]       mem [WHEELS];
    logic [WHEELS-1:0] valid_reg;
    logic [WHEELS-1:0] valid_next;

    logic [63:0]   rdata_reg;
    logic          rvalid_reg;

    logic          s1_v_reg;
    logic          s1_v_next;
    logic          s1_op_reg;
    logic          s1_up_reg;
    logic          s1_inr_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [1:0]    s1_wheel_reg;
    logic          fwd_hit_reg;
    logic [63:0]   fwd_data_reg;

    logic          accept;
    logic          in_range;
    logic [AW-1:0] addr;
    logic          s1_go;
    logic          wr_en;
    logic [63:0]   cur;
    logic [63:0]   wdata;
    logic [31:0]   step;
    logic [31:0]   delta;

    assign in_range  = ({3'b000, evt.wheel_index} < 5'(WHEELS));
    assign addr      = AW'(evt.wheel_index);
    // An edge request retires from the memory stage on its own; a sample
    // request waits until the speed pipeline can take it.
    assign s1_go     = s1_v_reg && ((s1_op_reg == OP_EDGE) || !smp_stall);
    assign evt_stall = s1_v_reg && !s1_go;
    assign accept    = evt_valid && !evt_stall;
    assign wr_en     = s1_go && s1_inr_reg;

    always_comb
    begin
        if (fwd_hit_reg)
            cur = fwd_data_reg;
        else if (rvalid_reg)
            cur = rdata_reg;
        else
            cur = 64'd0;

        step = s1_up_reg ? 32'd1 : 32'hFFFF_FFFF;
        if (s1_op_reg == OP_EDGE)
            wdata = {cur[63:32] + step, cur[31:0] + step};
        else
            wdata = {cur[63:32], 32'd0};

        delta      = s1_inr_reg ? cur[31:0] : 32'd0;
        smp.delta  = delta;
        smp.total  = s1_inr_reg ? cur[63:32] : 32'd0;
        smp.neg    = delta[31];
        smp.mag    = delta[31] ? (32'd0 - delta) : delta;
        smp.wheel  = s1_wheel_reg;

        s1_v_next = s1_v_reg;
        if (accept)
            s1_v_next = 1'b1;
        else if (s1_go)
            s1_v_next = 1'b0;

        valid_next = valid_reg;
        if (wr_en)
            valid_next[s1_addr_reg] = 1'b1;
    end

    assign smp_valid = s1_v_reg && (s1_op_reg == OP_SAMPLE);

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            rdata_reg <= mem[addr];
        end
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wdata;
        end
    end

    // The write of the retiring request lands on the same edge as the read of
    // the new one, so the RAM returns stale data; the written value is kept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rvalid_reg   <= in_range && valid_reg[addr];
            s1_op_reg    <= evt.opcode;
            s1_up_reg    <= (evt.a_level != evt.b_level);
            s1_inr_reg   <= in_range;
            s1_addr_reg  <= addr;
            s1_wheel_reg <= evt.wheel_index;
            fwd_hit_reg  <= wr_en && (s1_addr_reg == addr);
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ sv/qewc_spd.sv @@
`timescale 1ns / 1ps
// Speed pipeline: magnitude times scale, floor shift by 8, saturation to 48
// bits, and the result register. Elastic stages with per-stage valid.
// Depends on qewc_pkg for the sample record, result type and limits.
module qewc_spd
    import qewc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        smp_valid,
    output logic        smp_stall,
    input  qewc_smp_t   smp,
    input  logic [31:0] speed_scale,
    output logic        res_valid,
    input  logic        res_stall,
    output qewc_out_t   res
);

    logic        a_v_reg;
    logic        a_v_next;
    qewc_smp_t   a_reg;

    logic        b_v_reg;
    logic        b_v_next;
    logic [63:0] prod_reg;
    logic [31:0] b_delta_reg;
    logic [31:0] b_total_reg;
    logic        b_neg_reg;
    logic [1:0]  b_wheel_reg;

    logic        o_v_reg;
    logic        o_v_next;
    qewc_out_t   res_reg;

    logic        en_o;
    logic        en_b;
    logic        en_a;
    logic [64:0] nprod;
    logic [47:0] speed;

    assign en_o      = !o_v_reg || !res_stall;
    assign en_b      = !b_v_reg || en_o;
    assign en_a      = !a_v_reg || en_b;
    assign smp_stall = !en_a;

    always_comb
    begin
        a_v_next = en_a ? smp_valid : a_v_reg;
        b_v_next = en_b ? a_v_reg : b_v_reg;
        o_v_next = en_o ? b_v_reg : o_v_reg;

        // For a negative delta, floor(-p / 256) is an arithmetic shift of -p.
        // A zero product (zero scale) stays zero and does not saturate.
        nprod = 65'd0 - {1'b0, prod_reg};
        if (b_neg_reg)
            speed = ((&nprod[64:55]) || !(|nprod[64:55])) ? nprod[55:8] : SPEED_MIN;
        else
            speed = (|prod_reg[63:55]) ? SPEED_MAX : prod_reg[55:8];
    end

    always_ff @(posedge clk)
    begin
        if (en_a && smp_valid)
        begin
            a_reg <= smp;
        end
        if (en_b && a_v_reg)
        begin
            prod_reg    <= 64'(a_reg.mag) * 64'(speed_scale);
            b_delta_reg <= a_reg.delta;
            b_total_reg <= a_reg.total;
            b_neg_reg   <= a_reg.neg;
            b_wheel_reg <= a_reg.wheel;
        end
        if (en_o && b_v_reg)
        begin
            res_reg.delta_count  <= b_delta_reg;
            res_reg.total_count  <= b_total_reg;
            res_reg.speed_q8     <= speed;
            res_reg.sample_wheel <= b_wheel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            o_v_reg <= o_v_next;
        end
    end

    assign res_valid = o_v_reg;
    assign res       = res_reg;

endmodule

@@ sv/quad_encoder_wheel_counter_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// evt       in         evt_valid / evt_stall  qewc_in_t (opcode, wheel, A/B levels)
// res       out        res_valid / res_stall  qewc_out_t (delta, total, speed, wheel)
// apb       in/out     psel, penable, pready  speed scale register at address 0
//
// One request is accepted per cycle unless evt_stall holds it; the counter RAM
// read-modify-write with forwarding covers back-to-back requests to the same wheel.
// A sample result passes the RAM read at the edge that accepts its request,
// then the speed input register, the multiplier register and the
// saturation/result register.
// Reset clears the per-wheel valid bits, so all counters read as zero at once.
// A stalled result backs up through the speed stages; edge requests keep
// flowing until a sample request finds the speed pipeline full.
module quad_encoder_wheel_counter_unit
    import qewc_pkg::*;
#(
    parameter int WHEELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_stall,
    input  qewc_in_t    evt,
    output logic        res_valid,
    input  logic        res_stall,
    output qewc_out_t   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] speed_scale;
    logic        smp_valid;
    logic        smp_stall;
    qewc_smp_t   smp;

    qewc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .speed_scale (speed_scale)
    );

    qewc_ctr #(
        .WHEELS (WHEELS)
    ) u_ctr (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp)
    );

    qewc_spd u_spd (
        .clk         (clk),
        .rst_n       (rst_n),
        .smp_valid   (smp_valid),
        .smp_stall   (smp_stall),
        .smp         (smp),
        .speed_scale (speed_scale),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the quadrature encoder wheel counter unit: drives
// edge and sample requests with random gaps and stalls and checks every result.
// Depends on qewc_pkg and quad_encoder_wheel_counter_unit.
module testbench;
    import qewc_pkg::*;

    localparam int WHEEL_COUNT = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [2:0] SCALE_ADDR = {REG_SPEED_SCALE, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        evt_valid = 1'b0;
    logic        evt_stall;
    qewc_in_t    evt = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    qewc_out_t   res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model state of the counters and the scale register.
    logic [31:0] total_model [WHEEL_COUNT];
    logic [31:0] interval_model [WHEEL_COUNT];
    logic [31:0] speed_scale = SPEED_SCALE_RESET;

    qewc_in_t  pending_requests [$];
    qewc_out_t sample_expected [$];
    int        pushed_count = 0;
    int        accepted_count = 0;
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        evt_done = 1'b0;

    quad_encoder_wheel_counter_unit #(.WHEELS(WHEEL_COUNT)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    initial
    begin
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            total_model[i] = '0;
            interval_model[i] = '0;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    // Exact product, floored by the arithmetic shift, then clamped to 48 bits.
    function automatic logic [47:0] scaled_speed(logic [31:0] delta, logic [31:0] scale);
        logic signed [64:0] prod;
        logic signed [64:0] q;
        prod = $signed({{33{delta[31]}}, delta}) * $signed({33'd0, scale});
        q = prod >>> 8;
        if (q > $signed({17'd0, SPEED_MAX}))
            return SPEED_MAX;
        if (q < $signed({{17{1'b1}}, SPEED_MIN}))
            return SPEED_MIN;
        return q[47:0];
    endfunction

    task automatic count_wheel_event(qewc_in_t req);
        int        w;
        qewc_out_t want;
        w = int'(req.wheel_index);
        if (req.opcode == OP_EDGE)
        begin
            if (w < WHEEL_COUNT)
            begin
                // Equal A and B levels after an A edge mean reverse rotation.
                total_model[w] += (req.a_level == req.b_level) ? 32'hFFFF_FFFF : 32'd1;
                interval_model[w] += (req.a_level == req.b_level) ? 32'hFFFF_FFFF : 32'd1;
            end
        end
        else
        begin
            want = '0;
            want.sample_wheel = req.wheel_index;
            if (w < WHEEL_COUNT)
            begin
                want.delta_count = interval_model[w];
                want.total_count = total_model[w];
                want.speed_q8 = scaled_speed(interval_model[w], speed_scale);
                interval_model[w] = '0;
            end
            sample_expected.push_back(want);
        end
    endtask

    function automatic qewc_in_t make_req(logic op, int wheel, logic a, logic b);
        qewc_in_t req;
        req.opcode = op;
        req.wheel_index = 2'(wheel);
        req.a_level = a;
        req.b_level = b;
        return req;
    endfunction

    task automatic push_req(qewc_in_t req);
        pending_requests.push_back(req);
        pushed_count++;
    endtask

    // Driver: a request that is up stays unchanged until it has been accepted.
    always @(negedge clk)
    begin
        if (!rst_n)
            evt_valid <= 1'b0;
        else if (!evt_valid || evt_done)
        begin
            evt_done = 1'b0;
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                evt <= pending_requests.pop_front();
                evt_valid <= 1'b1;
            end
            else
                evt_valid <= 1'b0;
        end
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: checks results and feeds accepted requests to the model.
    always @(posedge clk)
    begin
        qewc_out_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (sample_expected.size() == 0)
                    report_mismatch("result with nothing pending", 64'(res.sample_wheel), '0);
                else
                begin
                    want = sample_expected.pop_front();
                    if (res.delta_count !== want.delta_count)
                        report_mismatch("delta_count", 64'(res.delta_count),
                                        64'(want.delta_count));
                    if (res.total_count !== want.total_count)
                        report_mismatch("total_count", 64'(res.total_count),
                                        64'(want.total_count));
                    if (res.speed_q8 !== want.speed_q8)
                        report_mismatch("speed_q8", 64'(res.speed_q8), 64'(want.speed_q8));
                    if (res.sample_wheel !== want.sample_wheel)
                        report_mismatch("sample_wheel", 64'(res.sample_wheel),
                                        64'(want.sample_wheel));
                end
            end
            if (evt_valid && !evt_stall)
            begin
                count_wheel_event(evt);
                accepted_count++;
                evt_done = 1'b1;
            end
        end
    end

    task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= SCALE_ADDR;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_scale(logic [31:0] value);
        logic [31:0] readback;
        apb_transfer(1'b1, value, readback);
        speed_scale = value;
        apb_transfer(1'b0, '0, readback);
        if (readback !== value)
            report_mismatch("speed_scale_q16 readback", 64'(readback), 64'(value));
    endtask

    // Waits until every request has been taken and every result has come back.
    task automatic wait_drained();
        while (accepted_count != pushed_count || sample_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_random(int count);
        qewc_in_t req;
        bit       forward;
        forward = 1'($urandom_range(0, 1));
        for (int n = 0; n < count; n++)
        begin
            req.opcode = ($urandom_range(0, 99) < 15) ? OP_SAMPLE : OP_EDGE;
            req.wheel_index = 2'($urandom_range(0, WHEEL_COUNT - 1));
            req.a_level = 1'($urandom_range(0, 1));
            req.b_level = 1'($urandom_range(0, 1));
            // Mostly a steady direction per phase so that deltas build up.
            if (req.opcode == OP_EDGE && $urandom_range(0, 99) < 75)
                req.b_level = forward ? ~req.a_level : req.a_level;
            push_req(req);
        end
    endtask

    initial
    begin
        logic [31:0] scales [6];
        scales[0] = 32'd0;
        scales[1] = 32'hFFFF_FFFF;
        scales[2] = 32'd1;
        scales[3] = 32'd255;
        scales[4] = $urandom;
        scales[5] = $urandom_range(0, 32'h0004_0000);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 88;

        // Directed part at the reset scale.
        for (int w = 0; w < WHEEL_COUNT; w++)
            push_req(make_req(OP_SAMPLE, w, 1'b0, 1'b0));
        push_req(make_req(OP_EDGE, 0, 1'b1, 1'b0));
        push_req(make_req(OP_EDGE, 0, 1'b0, 1'b1));
        push_req(make_req(OP_EDGE, 0, 1'b1, 1'b1));
        push_req(make_req(OP_SAMPLE, 0, 1'b0, 1'b0));
        push_req(make_req(OP_EDGE, 1, 1'b0, 1'b0));
        push_req(make_req(OP_EDGE, 1, 1'b1, 1'b1));
        push_req(make_req(OP_EDGE, 1, 1'b0, 1'b0));
        push_req(make_req(OP_SAMPLE, 1, 1'b1, 1'b1));
        push_req(make_req(OP_EDGE, 2, 1'b1, 1'b0));
        push_req(make_req(OP_SAMPLE, 2, 1'b0, 1'b1));
        push_req(make_req(OP_SAMPLE, 2, 1'b1, 1'b0));
        push_req(make_req(OP_EDGE, 3, 1'b0, 1'b1));
        push_req(make_req(OP_EDGE, 3, 1'b0, 1'b1));
        push_req(make_req(OP_SAMPLE, 3, 1'b0, 1'b0));
        push_req(make_req(OP_EDGE, 3, 1'b1, 1'b1));
        push_req(make_req(OP_SAMPLE, 3, 1'b1, 1'b1));
        push_req(make_req(OP_SAMPLE, 0, 1'b1, 1'b0));

        for (int phase = 0; phase < 6; phase++)
        begin
            // The sender holds off here until every pending result has come.
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (phase == 2)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 21;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_scale(scales[phase]);
            queue_random(100);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
